// ===== rtl/imupcf_pkg.sv =====
// ----------------------------------------------------------------------------
// imupcf_pkg
// shared types, constants and the arctangent table of the pitch filter
// ----------------------------------------------------------------------------
package imupcf_pkg;

  localparam int ATAN_TABLE_LEN       = 24;
  localparam int ANGLE_ITERATIONS_DEF = 16;
  localparam int QUEUE_DEPTH_DEF      = 2;
  localparam logic [15:0] BLEND_WEIGHT_RESET = 16'd64225;
  localparam logic signed [31:0] PITCH_LIMIT = 32'sd23592960;
  localparam logic [15:0] KEEP_WEIGHT = 16'd62259;
  localparam logic [15:0] NEW_WEIGHT  = 16'd3277;
  localparam logic signed [31:0] HALF_TURN = 32'sd11796480;

  // one raw sample
  typedef struct packed {
    logic signed [15:0] accel_x_raw;
    logic signed [15:0] accel_y_raw;
    logic signed [15:0] accel_z_raw;
    logic signed [15:0] gyro_x_raw;
    logic signed [15:0] gyro_y_raw;
    logic signed [15:0] gyro_z_raw;
    logic        [15:0] time_step;
  } sample_t;

  // one result
  typedef struct packed {
    logic signed [17:0] pitch_angle_out;
    logic signed [15:0] accel_x_out;
    logic signed [15:0] accel_y_smoothed_out;
    logic signed [15:0] accel_z_out;
    logic signed [15:0] gyro_x_out;
    logic signed [15:0] gyro_y_out;
    logic signed [15:0] gyro_z_out;
  } result_t;

  // work handed from front to back
  typedef struct packed {
    sample_t            raw;
    logic signed [23:0] smoothed;
    logic signed [33:0] delta;
  } job_t;

  function automatic logic [21:0] atan_entry(input logic [4:0] i);
    logic [21:0] v;
    case (i)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/imupcf_if.sv =====
// ----------------------------------------------------------------------------
// imupcf_if
// valid/ready channel carrying one payload
// ----------------------------------------------------------------------------
interface imupcf_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/imu_pitch_complementary_filter.sv =====
// path: front (multiply, reciprocal divide by 131), job queue, back (cordic
//   steps, blend multiply, sum, saturate); front and back overlap through
//   the job queue, and the front takes a new sample once it has pushed its job
// reset: synchronous, clears smoothed y, pitch, queue and sets blend weight 64225
// ----------------------------------------------------------------------------
// imu_pitch_complementary_filter
// pitch estimation from a six-axis sample by complementary filtering
// ----------------------------------------------------------------------------
module imu_pitch_complementary_filter import imupcf_pkg::*; #(
  parameter int ANGLE_ITERATIONS = ANGLE_ITERATIONS_DEF
) (
  input logic clk,
  input logic rst,
  imupcf_if.sink   in_ch,
  imupcf_if.sink   cfg,
  imupcf_if.source out_ch
);
  logic [15:0] blend_weight;
  logic        fq_valid, fq_ready, qb_valid, qb_ready;
  job_t        fq_data, qb_data;

  // configuration register
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) blend_weight <= BLEND_WEIGHT_RESET;
    else if (cfg.valid) blend_weight <= cfg.data;
  end

  imupcf_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_data(in_ch.data), .job_valid(fq_valid), .job_ready(fq_ready), .job_data(fq_data)
  );

  imupcf_queue u_queue (
    .clk(clk), .rst(rst), .push_valid(fq_valid), .push_ready(fq_ready),
    .push_data(fq_data), .pop_valid(qb_valid), .pop_ready(qb_ready), .pop_data(qb_data)
  );

  imupcf_back #(.ANGLE_ITERATIONS(ANGLE_ITERATIONS)) u_back (
    .clk(clk), .rst(rst), .blend_weight(blend_weight),
    .job_valid(qb_valid), .job_ready(qb_ready), .job_data(qb_data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
  );
endmodule

// ===== rtl/imupcf_ram.sv =====
// ----------------------------------------------------------------------------
// imupcf_ram
// generic single write, single read ram with registered read
// ----------------------------------------------------------------------------
module imupcf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end
endmodule

// ===== rtl/imupcf_front.sv =====
// ----------------------------------------------------------------------------
// imupcf_front
// accepts samples, updates smoothed y and forms the gyro increment
// ----------------------------------------------------------------------------
module imupcf_front import imupcf_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  sample_t in_data,
  output logic    job_valid,
  input  logic    job_ready,
  output job_t    job_data
);
  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MUL  = 2'd1;
  localparam logic [1:0] F_DIV  = 2'd2;
  localparam logic [1:0] F_PUSH = 2'd3;
  // ceil(2^39 / 131), exact floor division for dividends below 2^31
  localparam logic [31:0] RECIP_131 = 32'd4196609267;

  logic [1:0]         state;
  sample_t            raw;
  logic signed [23:0] smoothed;
  logic signed [40:0] keep_prod;
  logic signed [40:0] new_prod;
  logic               neg;
  logic [31:0]        mag;
  logic [31:0]        quo;
  logic [63:0]        quo_prod;
  logic signed [41:0] s_sum;

  assign in_ready  = (state == F_IDLE);
  assign job_valid = (state == F_PUSH);
  assign job_data  = '{raw: raw, smoothed: smoothed,
                       delta: neg ? -$signed({2'b00, quo}) : $signed({2'b00, quo})};

  assign s_sum   = 42'(keep_prod) + 42'(new_prod) + 42'sd32768;

  // sequencer: multiply, then divide by 131 through the reciprocal
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= F_IDLE;
      smoothed <= '0;
    end else begin
      case (state)
        F_IDLE: if (in_valid) begin
          raw       <= in_data;
          keep_prod <= 41'(smoothed) * $signed({1'b0, KEEP_WEIGHT});
          new_prod  <= 41'($signed({in_data.accel_y_raw, 8'd0})) * $signed({1'b0, NEW_WEIGHT});
          begin
            logic signed [32:0] g;
            g = 33'(in_data.gyro_x_raw) * $signed({1'b0, in_data.time_step});
            neg <= g[32];
            mag <= 32'(g[32] ? -g : g) + 32'd65;
          end
          state <= F_MUL;
        end
        F_MUL: begin
          smoothed <= s_sum[39:16];
          quo_prod <= 64'(mag) * 64'(RECIP_131);
          state    <= F_DIV;
        end
        F_DIV: begin
          quo   <= {7'd0, quo_prod[63:39]};
          state <= F_PUSH;
        end
        F_PUSH: if (job_ready) state <= F_IDLE;
        default: state <= F_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/imupcf_queue.sv =====
// ----------------------------------------------------------------------------
// imupcf_queue
// short fifo between front and back, storage in a ram
// ----------------------------------------------------------------------------
module imupcf_queue import imupcf_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output job_t pop_data
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;
  logic          out_valid;
  logic          loading;
  logic          loading_q;
  logic          push;
  logic          pop;
  job_t          ram_rd_data;
  job_t          out_data_q;

  assign push       = push_valid && push_ready;
  assign push_ready = (count < (AW+1)'(DEPTH));
  assign pop        = pop_valid && pop_ready;
  assign pop_valid  = out_valid;
  assign pop_data   = out_data_q;
  // fetch a stored entry into the output register when it is free
  assign loading    = (count != '0) && !loading_q && (!out_valid || pop);

  imupcf_ram #(.WIDTH($bits(job_t)), .DEPTH(1 << AW)) u_ram (
    .clk(clk), .wr_en(push), .wr_addr(wr_ptr), .wr_data(push_data),
    .rd_addr(rd_ptr), .rd_data(ram_rd_data)
  );

  // pointers, count and output state
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0; rd_ptr <= '0; count <= '0; out_valid <= 1'b0; loading_q <= 1'b0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      loading_q <= loading;
      if (loading) rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(loading);
      if (loading_q) out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;
    end
  end

  // output register, captures the ram word in the cycle after the read
  always_ff @(posedge clk) begin
    if (loading_q) out_data_q <= ram_rd_data;
  end
endmodule

// ===== rtl/imupcf_back.sv =====
// ----------------------------------------------------------------------------
// imupcf_back
// cordic angle, blend with gyro path, saturate and hold the result
// ----------------------------------------------------------------------------
module imupcf_back import imupcf_pkg::*; #(
  parameter int ANGLE_ITERATIONS = ANGLE_ITERATIONS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [15:0] blend_weight,
  input  logic        job_valid,
  output logic        job_ready,
  input  job_t        job_data,
  output logic        out_valid,
  input  logic        out_ready,
  output result_t     out_data
);
  localparam int STEPS = (ANGLE_ITERATIONS < ATAN_TABLE_LEN) ? ANGLE_ITERATIONS
                                                             : ATAN_TABLE_LEN;
  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_ROT  = 3'd1;
  localparam logic [2:0] B_MUL  = 3'd2;
  localparam logic [2:0] B_SUM  = 3'd3;
  localparam logic [2:0] B_SAT  = 3'd4;

  logic [2:0]         state;
  job_t               job;
  logic signed [31:0] pitch;
  logic signed [27:0] cx;
  logic signed [27:0] cy;
  logic signed [31:0] cz;
  logic [4:0]         it;
  logic signed [51:0] gyro_prod;
  logic signed [51:0] acc_prod;
  logic signed [52:0] blend_sum;
  logic signed [36:0] p_new;
  logic signed [27:0] xs;
  logic signed [27:0] ys;
  logic signed [31:0] tab;

  assign job_ready = (state == B_IDLE);
  assign xs  = cx >>> it;
  assign ys  = cy >>> it;
  assign tab = $signed({10'd0, atan_entry(it)});
  assign p_new = 37'(blend_sum >>> 16);

  // sequencer over rotation steps and blend
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      pitch     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != B_SAT) out_valid <= 1'b0;
      case (state)
        B_IDLE: if (job_valid && job_ready) begin
          logic signed [27:0] y0;
          logic signed [27:0] x0;
          y0 = 28'(job_data.smoothed);
          x0 = 28'($signed({job_data.raw.accel_z_raw, 8'd0}));
          job <= job_data;
          if (x0 == 0 && y0 == 0) begin
            // zero vector gives angle zero
            cx <= x0; cy <= y0; cz <= '0;
            it    <= 5'(STEPS);
            state <= B_MUL;
          end else begin
            it    <= '0;
            state <= B_ROT;
            if (x0 < 0) begin
              cx <= -x0; cy <= -y0;
              cz <= (y0 >= 0) ? HALF_TURN : -HALF_TURN;
            end else begin
              cx <= x0; cy <= y0; cz <= '0;
            end
          end
        end
        B_ROT: begin
          if (it == 5'(STEPS)) state <= B_MUL;
          else begin
            if (cy < 0) begin
              cx <= cx - ys; cy <= cy + xs; cz <= cz - tab;
            end else begin
              cx <= cx + ys; cy <= cy - xs; cz <= cz + tab;
            end
            it <= it + 5'd1;
          end
        end
        B_MUL: begin
          gyro_prod <= 52'(34'(pitch) + job.delta) * $signed({1'b0, blend_weight});
          acc_prod  <= 52'(cz) * $signed(18'(17'h10000 - {1'b0, blend_weight}));
          state     <= B_SUM;
        end
        B_SUM: begin
          blend_sum <= 53'(gyro_prod) + 53'(acc_prod) + 53'sd32768;
          state     <= B_SAT;
        end
        // finish once the output register is free
        B_SAT: if (!out_valid || out_ready) begin
          logic signed [31:0] p;
          if (p_new > 37'(PITCH_LIMIT)) p = PITCH_LIMIT;
          else if (p_new < -37'(PITCH_LIMIT)) p = -PITCH_LIMIT;
          else p = p_new[31:0];
          pitch     <= p;
          out_valid <= 1'b1;
          out_data  <= '{pitch_angle_out: 18'((p + 32'sd128) >>> 8),
                         accel_x_out: job.raw.accel_x_raw,
                         accel_y_smoothed_out: job.smoothed[23:8],
                         accel_z_out: job.raw.accel_z_raw,
                         gyro_x_out: job.raw.gyro_x_raw,
                         gyro_y_out: job.raw.gyro_y_raw,
                         gyro_z_out: job.raw.gyro_z_raw};
          state     <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/imupcf_checker.sv =====
// ----------------------------------------------------------------------------
// imupcf_checker
// port level checks of the pitch filter
// ----------------------------------------------------------------------------
module imupcf_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [17:0] pitch
);
  // a sample is not taken in the cycle right after one was taken
  a_gap: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("back to back accept");
  // pitch stays within plus or minus 360 degrees
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($signed(pitch) <= 18'sd92160 && $signed(pitch) >= -18'sd92160))
    else $error("pitch out of range");
  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pitch)) else $error("result dropped");
  // no result right after reset
  a_rst: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result after reset");
endmodule

bind imu_pitch_complementary_filter imupcf_checker u_checker (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .pitch(out_ch.data.pitch_angle_out)
);

// ===== tb/tb_imu_pitch_complementary_filter.sv =====
// ----------------------------------------------------------------------------
// tb_imu_pitch_complementary_filter
// checks pitch, smoothed y and pass-through fields of the pitch filter against
// a cycle-free predictor, under random idling on both channels and several
// blend weights
// ----------------------------------------------------------------------------
module tb_imu_pitch_complementary_filter;
  import imupcf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  imupcf_if #(.T(sample_t))     in_ch ();
  imupcf_if #(.T(logic [15:0])) cfg ();
  imupcf_if #(.T(result_t))     out_ch ();

  imu_pitch_complementary_filter uut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .cfg(cfg), .out_ch(out_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  logic [15:0]        pred_weight;
  logic signed [23:0] pred_smooth;
  logic signed [31:0] pred_pitch;

  sample_t pending_samples[$];
  result_t expected_results[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int errors = 0;
  int checked = 0;
  int cycles = 0;
  logic hold_send = 1'b0;

  function automatic longint fshift(longint v, int k);
    return v >>> k;
  endfunction

  // cordic angle of (y, x) in 1/65536 degree
  function automatic longint cordic_angle(longint y, longint x);
    longint z, xs, ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? 64'sd11796480 : -64'sd11796480;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < ANGLE_ITERATIONS_DEF && i < ATAN_TABLE_LEN; i++) begin
      xs = fshift(x, i);
      ys = fshift(y, i);
      if (y < 0) begin
        x = x - ys;
        y = y + xs;
        z -= longint'(atan_entry(5'(i)));
      end else begin
        x = x + ys;
        y = y - xs;
        z += longint'(atan_entry(5'(i)));
      end
    end
    return z;
  endfunction

  // advance filter state by one sample and return the result
  function automatic result_t filter_step(sample_t s);
    longint sm, ang, prod, dl, p, w;
    result_t r;
    w = longint'(pred_weight);
    sm = fshift(62259 * longint'(pred_smooth) +
                3277 * (longint'(s.accel_y_raw) * 256) + 32768, 16);
    pred_smooth = sm[23:0];
    ang = cordic_angle(sm, longint'(s.accel_z_raw) * 256);
    prod = longint'(s.gyro_x_raw) * longint'({1'b0, s.time_step});
    dl = (prod >= 0) ? (prod + 65) / 131 : -((-prod + 65) / 131);
    p = fshift(w * (longint'(pred_pitch) + dl) + (65536 - w) * ang + 32768, 16);
    if (p > 23592960) p = 23592960;
    if (p < -23592960) p = -23592960;
    pred_pitch = p[31:0];
    r.pitch_angle_out      = 18'(fshift(p + 128, 8));
    r.accel_x_out          = s.accel_x_raw;
    r.accel_y_smoothed_out = 16'(fshift(sm, 8));
    r.accel_z_out          = s.accel_z_raw;
    r.gyro_x_out           = s.gyro_x_raw;
    r.gyro_y_out           = s.gyro_y_raw;
    r.gyro_z_out           = s.gyro_z_raw;
    return r;
  endfunction

  // sample driver
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.data  <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) expected_results.push_back(filter_step(in_ch.data));
      if (pending_samples.size() > 0 && !hold_send &&
          $urandom_range(99) >= send_idle_pct) begin
        in_ch.valid <= 1'b1;
        in_ch.data  <= pending_samples.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected transaction: %p", out_ch.data);
        end else begin
          result_t e;
          e = expected_results.pop_front();
          checked++;
          if (e !== out_ch.data) begin
            errors++;
            if (errors <= 10) $display("expected %p\n  actual %p", e, out_ch.data);
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic add_sample(logic [15:0] ax, ay, az, gx, gy, gz, ts);
    sample_t s;
    s = {ax, ay, az, gx, gy, gz, ts};
    pending_samples.push_back(s);
  endtask

  task automatic add_random(int n);
    logic [15:0] ay, az;
    for (int i = 0; i < n; i++) begin
      // mostly near-level gravity vectors, sometimes anything
      if ($urandom_range(3) != 0) begin
        ay = 16'($signed($urandom_range(8000)) - 4000);
        az = 16'($signed($urandom_range(36000)) - 18000);
      end else begin
        ay = 16'($urandom);
        az = 16'($urandom);
      end
      add_sample(16'($urandom), ay, az, 16'($urandom), 16'($urandom), 16'($urandom),
                 ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(700)));
    end
  endtask

  task automatic drain();
    while (pending_samples.size() > 0 || in_ch.valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_weight(logic [15:0] w);
    @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.data  <= w;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    pred_weight = w;
  endtask

  // timeout
  always @(posedge clk) begin
    if (cycles > LIMIT_CYCLES) begin
      $display("imu_pitch_complementary_filter: mismatch");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    out_ch.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.data  = '0;
    pred_weight = BLEND_WEIGHT_RESET;
    pred_smooth = '0;
    pred_pitch  = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: zero vector, extremes, zero time step, saturation drive
    add_sample(0, 0, 0, 0, 0, 0, 0);
    add_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'hffff);
    add_sample(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'hffff);
    add_sample(16'hffff, 16'h7fff, 16'h8000, 16'h0001, 16'hffff, 16'h0001, 0);
    add_sample(0, 16'h8000, 16'h7fff, 16'h7fff, 0, 0, 16'hffff);
    add_sample(0, 0, 16'h8000, 16'hffff, 0, 0, 1);
    for (int i = 0; i < 8; i++)
      add_sample(0, 16'h4000, 0, 16'h7fff, 0, 0, 16'hffff);
    for (int i = 0; i < 4; i++)
      add_sample(0, 16'hc000, 16'hc000, 16'h8000, 0, 0, 16'hffff);
    drain();

    // weight extremes and reset value, with idling patterns
    send_idle_pct = 7; recv_idle_pct = 60;
    write_weight(16'hffff); add_random(250); drain();
    write_weight(16'h0000); add_random(200); drain();
    send_idle_pct = 60; recv_idle_pct = 7;
    write_weight(16'd32768); add_random(250);
    // hold the sender until the block is empty
    wait (pending_samples.size() < 120);
    hold_send = 1'b1;
    while (in_ch.valid || expected_results.size() > 0) @(posedge clk);
    hold_send = 1'b0;
    drain();
    send_idle_pct = 0; recv_idle_pct = 0;
    write_weight(BLEND_WEIGHT_RESET); add_random(350); drain();
    write_weight(16'($urandom)); add_random(280); drain();

    $display("covered %0d results over five blend weights incl. 0 and 65535,", checked);
    $display("with sender/receiver idling, a full drain pause and saturating pitch");
    if (errors == 0) begin
      $display("imu_pitch_complementary_filter: match");
    end else begin
      $display("imu_pitch_complementary_filter: mismatch");
    end
    $finish;
  end
endmodule
